>>> rtl/ntis_pkg.sv
// shared constants and types for the nearest time index search
package ntis_pkg;

  // table geometry
  localparam int DEPTH     = 4096;
  localparam int TIME_BITS = 48;
  localparam int ADDR_W    = $clog2(DEPTH);
  // row count register holds 0..2*DEPTH-1, wide enough for DEPTH itself
  localparam int CNT_W     = ADDR_W + 1;
  // signed search bounds, room for -1 and the sum of two bounds
  localparam int IDX_W     = ADDR_W + 2;

  // word commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef logic [TIME_BITS-1:0]    time_t;
  typedef logic [ADDR_W-1:0]       addr_t;
  typedef logic signed [IDX_W-1:0] idx_t;

  // search sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_PROBE,
    ST_NEAR_MID,
    ST_NEAR_HI,
    ST_NEAR_END,
    ST_PICK,
    ST_EMIT
  } state_t;

endpackage

>>> rtl/ntis_ram.sv
// generic single write port ram with registered read
module ntis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/nearest_time_index_search.sv
// Nearest time index search over a table of ascending timestamps held in one RAM.
// A write word (cmd 0) stores entry_time at entry_index and gives
// no result; the block is ready again in the next cycle. A query word (cmd 1) runs a
// binary search over entries 0 to row_count-1 (row_count above the table depth acts
// as the depth), then picks the nearest of the entries around the final high bound,
// ties going to the higher index, so an equally near next entry wins when it exists.
// An exact hit returns its index at once, and a table of at most one entry answers 0.
// A query holds the input off from its start state through its probe states, and
// through the nearest-of-three states when that choice runs, until its emit state
// hands the result to the output register: the single RAM read port
// takes one address per cycle and one shared compare and absolute difference unit
// handles each returned entry. The result sits in an output register, so a taken
// result frees the block even while the consumer stalls, up to the point where the
// next query result is ready; from there the input stays off until the consumer
// takes the waiting word. Entries must be written before a query reads them.
module nearest_time_index_search (
  input  logic                       clk,
  input  logic                       rst_n,
  // input words
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_cmd,
  input  logic [ntis_pkg::ADDR_W-1:0]    in_entry_index,
  input  logic [ntis_pkg::TIME_BITS-1:0] in_entry_time,
  input  logic [ntis_pkg::TIME_BITS-1:0] in_query_time,
  // result words
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ntis_pkg::ADDR_W-1:0]    out_found_index,
  // row count register
  input  logic                       cfg_wr_en,
  input  logic [ntis_pkg::CNT_W-1:0] cfg_wr_data
);

  import ntis_pkg::*;

  state_t        state_r, state_nxt;
  logic [CNT_W-1:0] row_count_r;
  logic [CNT_W-1:0] rows_r, rows_nxt;
  time_t         query_r, query_nxt;
  idx_t          low_r, low_nxt;
  idx_t          high_r, high_nxt;
  idx_t          mid_r, mid_nxt;
  time_t         d1_r, d1_nxt;
  time_t         d2_r, d2_nxt;
  time_t         d3_r, d3_nxt;
  addr_t         res_r, res_nxt;
  logic          out_valid_r, out_valid_nxt;
  addr_t         out_index_r, out_index_nxt;

  logic          in_acc;
  logic          ram_we;
  addr_t         ram_raddr;
  time_t         ram_rdata;

  // shared compare and distance unit
  logic          q_lt, q_eq;
  time_t         abs_gap;

  // search decision signals
  idx_t          probe_lo, probe_hi;
  idx_t          cur_lo, cur_hi, cur_mid;
  idx_t          rows_s;
  logic          hit, dec_zero, dec_near, has_next;
  logic [CNT_W-1:0] rows_clamp;
  idx_t          rd_idx;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign ram_we    = in_acc && (in_cmd == CMD_WRITE);
  assign out_valid = out_valid_r;
  assign out_found_index = out_index_r;

  // sample table
  ntis_ram #(
    .WIDTH(TIME_BITS),
    .DEPTH(DEPTH)
  ) u_times (
    .clk  (clk),
    .we   (ram_we),
    .waddr(in_entry_index),
    .wdata(in_entry_time),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // shared unit: compare query against the returned entry, absolute distance
  assign q_lt    = query_r < ram_rdata;
  assign q_eq    = query_r == ram_rdata;
  assign abs_gap = q_lt ? (ram_rdata - query_r) : (query_r - ram_rdata);

  // clamp the row count to the table depth
  assign rows_clamp = (row_count_r > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : row_count_r;
  assign rows_s     = idx_t'({1'b0, rows_r});

  // bounds after the current probe, then the next step decision
  always_comb begin
    probe_lo = (!q_lt && !q_eq) ? (mid_r + idx_t'(1)) : low_r;
    probe_hi = q_lt ? (mid_r - idx_t'(1)) : high_r;
    if (state_r == ST_PROBE) begin
      cur_lo = probe_lo;
      cur_hi = probe_hi;
      hit    = q_eq;
    end else begin
      cur_lo = low_r;
      cur_hi = high_r;
      hit    = 1'b0;
    end
    cur_mid  = (cur_lo + cur_hi) >>> 1;
    dec_zero = cur_hi <= idx_t'(0);
    dec_near = cur_lo >= cur_hi;
    has_next = (high_r + idx_t'(1)) < rows_s;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_cmd == CMD_QUERY) begin
          state_nxt = ST_START;
        end
      end
      ST_START, ST_PROBE: begin
        if (hit || dec_zero) begin
          state_nxt = ST_EMIT;
        end else if (dec_near) begin
          state_nxt = ST_NEAR_MID;
        end else begin
          state_nxt = ST_PROBE;
        end
      end
      ST_NEAR_MID: state_nxt = ST_NEAR_HI;
      ST_NEAR_HI:  state_nxt = ST_NEAR_END;
      ST_NEAR_END: state_nxt = ST_PICK;
      ST_PICK:     state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    rows_nxt      = rows_r;
    query_nxt     = query_r;
    low_nxt       = low_r;
    high_nxt      = high_r;
    mid_nxt       = mid_r;
    d1_nxt        = d1_r;
    d2_nxt        = d2_r;
    d3_nxt        = d3_r;
    res_nxt       = res_r;
    out_index_nxt = out_index_r;
    out_valid_nxt = out_valid_r && !out_ready;
    rd_idx        = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_cmd == CMD_QUERY) begin
          rows_nxt  = rows_clamp;
          query_nxt = in_query_time;
          low_nxt   = '0;
          high_nxt  = idx_t'({1'b0, rows_clamp}) - idx_t'(1);
        end
      end
      ST_START, ST_PROBE: begin
        low_nxt  = cur_lo;
        high_nxt = cur_hi;
        mid_nxt  = cur_mid;
        if (hit) begin
          res_nxt = mid_r[ADDR_W-1:0];
        end else begin
          res_nxt = '0;
        end
        // read the midpoint, or the entry below high for the final choice
        rd_idx = dec_near ? (cur_hi - idx_t'(1)) : cur_mid;
      end
      ST_NEAR_MID: begin
        d1_nxt = abs_gap;
        rd_idx = high_r;
      end
      ST_NEAR_HI: begin
        d2_nxt = abs_gap;
        rd_idx = has_next ? (high_r + idx_t'(1)) : high_r;
      end
      ST_NEAR_END: begin
        d3_nxt = has_next ? abs_gap : d2_r;
      end
      ST_PICK: begin
        // ties favor the higher index, so an equally near next entry wins when it exists
        if (d1_r < d2_r) begin
          if (d1_r < d3_r) begin
            res_nxt = ADDR_W'(high_r - idx_t'(1));
          end else begin
            res_nxt = has_next ? ADDR_W'(high_r + idx_t'(1)) : ADDR_W'(high_r);
          end
        end else if (d2_r < d3_r) begin
          res_nxt = ADDR_W'(high_r);
        end else begin
          res_nxt = has_next ? ADDR_W'(high_r + idx_t'(1)) : ADDR_W'(high_r);
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_index_nxt = res_r;
        end
      end
      default: begin
        rd_idx = '0;
      end
    endcase
    ram_raddr = rd_idx[ADDR_W-1:0];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      row_count_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        row_count_r <= cfg_wr_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rows_r      <= rows_nxt;
    query_r     <= query_nxt;
    low_r       <= low_nxt;
    high_r      <= high_nxt;
    mid_r       <= mid_nxt;
    d1_r        <= d1_nxt;
    d2_r        <= d2_nxt;
    d3_r        <= d3_nxt;
    res_r       <= res_nxt;
    out_index_r <= out_index_nxt;
  end

endmodule

>>> rtl/ntis_checker.sv
// port level checks for the nearest time index search, bound to the top level
module ntis_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           in_cmd,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [ntis_pkg::ADDR_W-1:0]    out_found_index
);

  import ntis_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found_index))
    else $error("result word changed while stalled");

  // a query keeps the block busy in the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd == CMD_QUERY |=> !in_ready)
    else $error("input ready right after a query");

  // a write leaves the block ready in the next cycle
  a_write_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd == CMD_WRITE |=> in_ready)
    else $error("block busy after a write");

  // a new result only appears at the end of a search
  a_result_from_search: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a search");

endmodule

bind nearest_time_index_search ntis_checker u_ntis_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_cmd         (in_cmd),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_found_index(out_found_index)
);

>>> tb/nearest_time_index_search_test.sv
`timescale 1ns / 100ps
// self-checking testbench for the nearest time index search block
module nearest_time_index_search_test;
  import ntis_pkg::*;

  // one input word as the driver presents it
  typedef struct packed {
    logic  cmd;
    addr_t slot;
    time_t stamp;
    time_t qtime;
  } word_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             in_cmd = CMD_WRITE;
  addr_t            in_entry_index = '0;
  time_t            in_entry_time = '0;
  time_t            in_query_time = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  addr_t            out_found_index;
  logic             cfg_wr_en = 1'b0;
  logic [CNT_W-1:0] cfg_wr_data = '0;

  // predictor state, updated in acceptance order
  time_t tick_table [DEPTH];
  int    row_lim = 0;
  addr_t found_q [$];

  // stimulus side bookkeeping, ahead of the block
  bit [TIME_BITS-1:0] gen_ticks [DEPTH];
  bit                 gen_written [DEPTH];
  word_t              word_q [$];
  int                 words_pushed = 0;
  int                 words_taken = 0;

  // driver and monitor state
  word_t    cur_word;
  int       burst_left = 1;
  int       gap_left = 0;
  bit       tx_steady = 1'b0;
  bit [7:0] stall_pat = 8'hFF;
  int       pat_left = 0;
  int       hold_left = 0;
  int       results_seen = 0;
  int       mism_cnt = 0;
  addr_t    want;

  nearest_time_index_search u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_entry_index  (in_entry_index),
    .in_entry_time   (in_entry_time),
    .in_query_time   (in_query_time),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_found_index (out_found_index),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  always #1 clk = ~clk;

  function automatic time_t rand_ticks();
    return time_t'({$urandom(), $urandom()});
  endfunction

  function automatic time_t tick_gap(input time_t a, input time_t b);
    return (a > b) ? a - b : b - a;
  endfunction

  // nearest of entries hi-1, hi and hi+1; hi+1 only counts when inside the rows
  function automatic addr_t pick_of_three(input int hi, input int rows, input time_t q);
    time_t t1, t2, t3, d1, d2, d3;
    bit    nxt;
    t1  = tick_table[hi-1];
    t2  = tick_table[hi];
    nxt = (hi + 1) < rows;
    t3  = nxt ? tick_table[hi+1] : t2;
    d1  = tick_gap(q, t1);
    d2  = tick_gap(q, t2);
    d3  = tick_gap(q, t3);
    if (d1 < d2) return addr_t'((d1 < d3) ? hi - 1 : (nxt ? hi + 1 : hi));
    if (d2 < d3) return addr_t'(hi);
    return addr_t'(nxt ? hi + 1 : hi);
  endfunction

  // binary search over the predicted table, exact hit returns at once
  function automatic addr_t nearest_index(input time_t q);
    int rows, lo, hi, md;
    rows = (row_lim > DEPTH) ? DEPTH : row_lim;
    lo   = 0;
    hi   = rows - 1;
    while (hi > 0 && lo < hi) begin
      md = (lo + hi) / 2;
      if (q == tick_table[md]) return addr_t'(md);
      if (q < tick_table[md]) hi = md - 1;
      else lo = md + 1;
    end
    if (hi <= 0) return '0;
    return pick_of_three(hi, rows, q);
  endfunction

  // length of the run of written entries from index 0
  function automatic int prefix_len();
    int n;
    n = 0;
    while (n < DEPTH && gen_written[n]) n++;
    return n;
  endfunction

  // query time near a table entry, between neighbors, or anywhere
  function automatic time_t pick_ticks(input int rows);
    int    span, i;
    time_t a;
    span = (rows > DEPTH) ? DEPTH : rows;
    i    = (span < 2) ? 0 : $urandom_range(0, span - 2);
    a    = gen_ticks[i];
    case ($urandom_range(0, 7))
      0: return a;
      1: return a + 1;
      2: return a - 1;
      3: return a + (time_t'(gen_ticks[i+1]) - a) / 2;
      4: return rand_ticks();
      5: return '0;
      6: return '1;
      default: return a + time_t'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_write(input addr_t idx, input time_t t);
    word_t w;
    w.cmd   = CMD_WRITE;
    w.slot  = idx;
    w.stamp = t;
    w.qtime = rand_ticks();
    gen_ticks[idx]   = t;
    gen_written[idx] = 1'b1;
    word_q.push_back(w);
    words_pushed++;
  endtask

  task automatic push_query(input time_t q);
    word_t w;
    w.cmd   = CMD_QUERY;
    w.slot  = addr_t'($urandom());
    w.stamp = rand_ticks();
    w.qtime = q;
    word_q.push_back(w);
    words_pushed++;
  endtask

  // predictor update for a word the block has taken
  task automatic take_word(input word_t w);
    if (w.cmd == CMD_QUERY) found_q.push_back(nearest_index(w.qtime));
    else tick_table[w.slot] = w.stamp;
    words_taken++;
  endtask

  // wait until every word is taken and every result is back, then let the block go quiet
  task automatic settle();
    while (words_taken != words_pushed || found_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_rows(input int v);
    settle();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v[CNT_W-1:0];
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    row_lim = v;
  endtask

  // ascending table from entry 0, steps may be zero or kept even to force ties
  task automatic fill_sorted(input int n);
    time_t       t;
    int unsigned smax, step;
    bit          even;
    t    = rand_ticks() >> $urandom_range(2, 47);
    smax = 32'd1 << $urandom_range(0, 30);
    even = $urandom_range(0, 1);
    for (int i = 0; i < n; i++) begin
      push_write(addr_t'(i), t);
      step = $urandom_range(0, smax);
      if (even) step = step & ~32'd1;
      t = t + time_t'(step);
    end
  endtask

  // one entry of the ascending line base + i * step, written only when it differs
  task automatic put_line(input int i, input time_t base, input time_t step);
    time_t t;
    t = base + time_t'(i) * step;
    if (!gen_written[i] || gen_ticks[i] != t) push_write(addr_t'(i), t);
  endtask

  // write just the entries that a search for q over the rows will read
  task automatic fill_path(input time_t q, input int rows, input time_t base,
                           input time_t step);
    int lim, lo, hi, md;
    lim = (rows > DEPTH) ? DEPTH : rows;
    lo  = 0;
    hi  = lim - 1;
    while (hi > 0 && lo < hi) begin
      md = (lo + hi) / 2;
      put_line(md, base, step);
      if (q == gen_ticks[md]) return;
      if (q < gen_ticks[md]) hi = md - 1;
      else lo = md + 1;
    end
    if (hi > 0) begin
      put_line(hi - 1, base, step);
      put_line(hi, base, step);
      if (hi + 1 < lim) put_line(hi + 1, base, step);
    end
  endtask

  // queries over a sparsely written full table, stray writes mixed in
  task automatic run_wide_queries(input int k, input int rows, input time_t base,
                                  input time_t step, input bit noisy);
    time_t a, q;
    for (int j = 0; j < k; j++) begin
      if (noisy && $urandom_range(0, 7) == 0) begin
        push_write(addr_t'($urandom_range(0, DEPTH - 1)), rand_ticks());
      end else begin
        a = base + time_t'($urandom_range(0, DEPTH - 1)) * step;
        case ($urandom_range(0, 7))
          0: q = a;
          1: q = a + 1;
          2: q = a - 1;
          3: q = a + step / 2;
          4: q = rand_ticks();
          5: q = '0;
          6: q = '1;
          default: q = a + time_t'($urandom_range(0, 255));
        endcase
        fill_path(q, rows, base, step);
        push_query(q);
      end
    end
  endtask

  // queries with an occasional stray write mixed in
  task automatic run_queries(input int k, input int rows, input bit noisy);
    int lim;
    lim = (rows > DEPTH) ? DEPTH : rows;
    if (lim < 1) lim = 1;
    for (int j = 0; j < k; j++) begin
      if (noisy && $urandom_range(0, 7) == 0) begin
        if ($urandom_range(0, 1) == 0)
          push_write(addr_t'($urandom_range(0, DEPTH - 1)), rand_ticks());
        else
          push_write(addr_t'($urandom_range(0, lim - 1)), rand_ticks());
      end else begin
        push_query(pick_ticks(rows));
      end
    end
  endtask

  // input driver: bursts with random gaps, valid held until taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) take_word(cur_word);
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (word_q.size() > 0) begin
          cur_word = word_q.pop_front();
          in_cmd         <= cur_word.cmd;
          in_entry_index <= cur_word.slot;
          in_entry_time  <= cur_word.stamp;
          in_query_time  <= cur_word.qtime;
          in_valid       <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = (tx_steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (found_q.size() == 0) begin
          mism_cnt++;
          if (mism_cnt <= 20)
            $display("%0t: unexpected result, expected none, actual found_index %0d",
                     $time, out_found_index);
        end else begin
          want = found_q.pop_front();
          if (out_found_index !== want) begin
            mism_cnt++;
            if (mism_cnt <= 20)
              $display("%0t: found_index expected %0d, actual %0d",
                       $time, want, out_found_index);
          end
        end
        results_seen++;
        // long hold-off so the output register fills and the input backs up
        if (results_seen % 470 == 30) hold_left = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (pat_left == 0) begin
          stall_pat = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom()) | 8'h01);
          pat_left  = 32;
        end
        out_ready <= stall_pat[0];
        stall_pat = {stall_pat[0], stall_pat[7:1]};
        pat_left--;
      end
    end
  end

  // stimulus sequence
  initial begin
    int    first_rand, phase, n, rows;
    time_t fbase, fstep;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // empty table after reset answers 0
    push_query('0);
    push_query('1);
    // small hand-built table with extreme times and the top index
    push_write(addr_t'(0), time_t'(0));
    push_write(addr_t'(1), time_t'(100));
    push_write(addr_t'(2), time_t'(200));
    push_write(addr_t'(3), time_t'(300));
    push_write(addr_t'(4), '1);
    push_write('1, '1);
    // single entry
    set_rows(1);
    push_query(time_t'(150));
    // two entries, query midway
    set_rows(2);
    push_query(time_t'(50));
    // exact hits, ties, and points between entries
    set_rows(5);
    push_query(time_t'(200));
    push_query(time_t'(150));
    push_query(time_t'(250));
    push_query(time_t'(0));
    push_query('1);
    push_query(time_t'(101));
    push_query(time_t'(299));
    push_query(time_t'(1000));
    push_query({1'b1, {(TIME_BITS-1){1'b0}}});

    first_rand = words_pushed;
    phase = 0;
    while (words_pushed - first_rand < 950 || phase < 3) begin
      phase++;
      tx_steady = ($urandom_range(0, 3) == 0);
      if (phase == 3) begin
        // full table rows with only the searched entries written,
        // then row counts at and beyond the depth
        fbase = rand_ticks() >> $urandom_range(8, 47);
        fstep = time_t'($urandom_range(1, 32'd1 << $urandom_range(0, 20)));
        set_rows(DEPTH);
        run_wide_queries(16, DEPTH, fbase, fstep, 1'b0);
        set_rows(8191);
        run_wide_queries(10, 8191, fbase, fstep, 1'b1);
        set_rows($urandom_range(DEPTH + 1, 8190));
        run_wide_queries(6, DEPTH, fbase, fstep, 1'b0);
      end else begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(65, 600) : $urandom_range(2, 64);
        fill_sorted(n);
        // a few stray entries leave the table out of order
        if ($urandom_range(0, 4) == 0)
          repeat ($urandom_range(1, 3))
            push_write(addr_t'($urandom_range(0, n - 1)), rand_ticks());
        case ($urandom_range(0, 5))
          0: rows = $urandom_range(0, n);
          1: rows = prefix_len();
          default: rows = n;
        endcase
        set_rows(rows);
        run_queries($urandom_range(8, 30), rows, 1'b1);
      end
    end

    settle();
    if (mism_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // run limit
  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> files.f
rtl/ntis_pkg.sv
rtl/ntis_ram.sv
rtl/nearest_time_index_search.sv
rtl/ntis_checker.sv
tb/nearest_time_index_search_test.sv
